// ===== rtl/dhc_pkg.sv =====
// Package for the disparity-to-hue colour unit.
// Widths, register indexes, sequencer states, divider request type and helpers.
// No dependencies.
package dhc_pkg;

    localparam int PIX_W  = 8;
    localparam int CH_W   = 8;
    localparam int LVL_W  = 9;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 9;
    localparam int DIVD_W = 16;
    localparam int FRAC_W = 6;
    localparam int KW     = 17;
    localparam int NW     = 27;

    localparam logic [LVL_W-1:0] LVL_ONE = 9'd256;
    localparam logic signed [KW-1:0] K_FULL = 17'sd15360;
    localparam logic signed [NW-1:0] DEN = 27'sd3932160;
    localparam logic [FRAC_W-1:0] SIXTY = 6'd60;

    typedef enum logic [CIDX_W-1:0] {
        REG_MAX_DISP = 2'd0,
        REG_SAT      = 2'd1,
        REG_VAL      = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        K_P,
        K_Q,
        K_T,
        K_V
    } kind_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [PIX_W-1:0]  divisor;
    } div_req_t;

    // HSV sector table: which term feeds channel ch (0 blue, 1 green, 2 red)
    function automatic kind_t chan_kind(input logic [2:0] hi, input logic [1:0] ch);
        kind_t b;
        kind_t g;
        kind_t r;
        case (hi)
            3'd0:    begin b = K_P; g = K_T; r = K_V; end
            3'd1:    begin b = K_P; g = K_V; r = K_Q; end
            3'd2:    begin b = K_T; g = K_V; r = K_P; end
            3'd3:    begin b = K_V; g = K_Q; r = K_P; end
            3'd4:    begin b = K_V; g = K_P; r = K_T; end
            default: begin b = K_Q; g = K_P; r = K_V; end
        endcase
        case (ch)
            2'd0:    chan_kind = b;
            2'd1:    chan_kind = g;
            default: chan_kind = r;
        endcase
    endfunction

endpackage

// ===== rtl/dhc_if.sv =====
// Channel interfaces for the disparity-to-hue colour unit.
// Pixel request, colour result and configuration write; depends on dhc_pkg.
interface dhc_pix_if;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [dhc_pkg::PIX_W-1:0] pixel;
    logic                     frame_start;
    modport source (output valid, output op, output pixel, output frame_start, input ready);
    modport sink   (input valid, input op, input pixel, input frame_start, output ready);
endinterface

interface dhc_rgb_if;
    logic                     valid;
    logic                     ready;
    logic [dhc_pkg::CH_W-1:0] blue;
    logic [dhc_pkg::CH_W-1:0] green;
    logic [dhc_pkg::CH_W-1:0] red;
    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface dhc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dhc_pkg::CIDX_W-1:0] index;
    logic [dhc_pkg::CDAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dhc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, 8 quotient bits.
// Caller guarantees the quotient fits in 8 bits; depends on dhc_pkg.
module dhc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dhc_pkg::div_req_t          req,
    output logic                       done,
    output logic [dhc_pkg::PIX_W-1:0]  quotient
);
    import dhc_pkg::*;

    logic [PIX_W-1:0] rem_reg, rem_next;
    logic [PIX_W-1:0] quo_reg, quo_next;
    logic [PIX_W-1:0] dsr_reg, dsr_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PIX_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[PIX_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend[DIVD_W-1:PIX_W];
            quo_next  = req.dividend[PIX_W-1:0];
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? PIX_W'(trial - {1'b0, dsr_reg}) : trial[PIX_W-1:0];
            quo_next = {quo_reg[PIX_W-2:0], fits};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/dhc_chan.sv =====
// Shared channel unit: k = 15360 - x*S, then n = V*k, clamp and scale by 255.
// Two register stages, one channel issued per cycle; depends on dhc_pkg.
module dhc_chan (
    input  logic                       clk,
    input  logic [dhc_pkg::FRAC_W-1:0] x,
    input  logic [dhc_pkg::LVL_W-1:0]  sat,
    input  logic [dhc_pkg::LVL_W-1:0]  val,
    output logic [dhc_pkg::CH_W-1:0]   chan
);
    import dhc_pkg::*;

    logic [14:0]            xs;
    logic signed [KW-1:0]   k_reg, k_next;
    logic signed [LVL_W:0]  vs;
    logic signed [NW-1:0]   n;
    logic [NW-1:0]          scaled;
    logic [CH_W-1:0]        chan_reg, chan_next;

    always_comb
    begin
        xs     = 15'(x) * 15'(sat);
        k_next = K_FULL - $signed({2'b00, xs});
    end

    always_comb
    begin
        vs     = $signed({1'b0, val});
        n      = NW'(vs) * NW'(k_reg);
        scaled = NW'(n[21:0]) * NW'(17);
        if (n <= 0)
            chan_next = '0;
        else if (n >= DEN)
            chan_next = 8'd255;
        else
            chan_next = scaled[25:18];
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

// ===== rtl/disparity_to_hue_color_unit.sv =====
// Top level of the disparity-to-hue colour unit: sequencer, registers, state.
// Depends on dhc_pkg, dhc_if, dhc_div and dhc_chan.
//
// A scan request (op 0) updates the running maximum; the sequencer stays idle.
// A colour request (op 1) runs from acceptance to the next acceptance in steps:
// set up at acceptance, 8 steps of the divider for the hue plus one to finish,
// the shared two-stage channel unit (one channel issued per cycle), and the
// load of the output register, which waits until that register is free. Pixels
// that come out black (zero pixel or zero maximum) skip the arithmetic and go
// straight to the load. The result sits in an output register, so the next
// request is taken while it waits. Configuration writes are always ready.
module disparity_to_hue_color_unit (
    input  logic       clk,
    input  logic       rst_n,
    dhc_pix_if.sink    pix_in,
    dhc_rgb_if.source  pix_out,
    dhc_cfg_if.sink    cfg
);
    import dhc_pkg::*;

    state_t state_reg, state_next;

    logic [PIX_W-1:0] max_disp_reg, max_disp_next;
    logic [LVL_W-1:0] sat_reg, sat_next;
    logic [LVL_W-1:0] val_reg, val_next;
    logic [PIX_W-1:0] run_max_reg, run_max_next;

    logic             black_reg, black_next;
    logic [2:0]       mul_cnt_reg, mul_cnt_next;
    logic [2:0]       hi_reg, hi_next;
    logic [FRAC_W-1:0] r_reg, r_next;
    logic [CH_W-1:0]  blue_reg, blue_next;
    logic [CH_W-1:0]  green_reg, green_next;
    logic [CH_W-1:0]  red_reg, red_next;

    logic             out_valid_reg, out_valid_next;
    logic [CH_W-1:0]  out_b_reg, out_b_next;
    logic [CH_W-1:0]  out_g_reg, out_g_next;
    logic [CH_W-1:0]  out_r_reg, out_r_next;

    logic             accept;
    logic             out_free;
    logic [PIX_W-1:0] m_sel;
    logic [PIX_W-1:0] d_clamp;
    logic [PIX_W-1:0] diff;
    logic [PIX_W-1:0] scan_base;
    logic             is_black;
    div_req_t         div_req;
    logic             div_done;
    logic [PIX_W-1:0] quotient;
    kind_t            kind;
    logic [FRAC_W-1:0] x_sel;
    logic [CH_W-1:0]  chan;

    dhc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    dhc_chan u_chan (
        .clk  (clk),
        .x    (x_sel),
        .sat  (sat_reg),
        .val  (val_reg),
        .chan (chan)
    );

    assign accept   = pix_in.valid && pix_in.ready;
    assign out_free = !out_valid_reg || pix_out.ready;

    always_comb
    begin
        m_sel    = (max_disp_reg != '0) ? max_disp_reg : run_max_reg;
        d_clamp  = (pix_in.pixel > m_sel) ? m_sel : pix_in.pixel;
        diff     = m_sel - d_clamp;
        is_black = (m_sel == '0) || (pix_in.pixel == '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && pix_in.op)
                    state_next = is_black ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == 3'd4)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pix_in.ready     = (state_reg == ST_IDLE);
        cfg.ready        = 1'b1;
        div_req.start    = accept && pix_in.op && !is_black;
        div_req.dividend = {diff, 8'd0} - {4'd0, diff, 4'd0};
        div_req.divisor  = m_sel;
        kind  = chan_kind(hi_reg, mul_cnt_reg[1:0]);
        x_sel = '0;
        case (kind)
            K_P:     x_sel = SIXTY;
            K_Q:     x_sel = r_reg;
            K_T:     x_sel = SIXTY - r_reg;
            default: x_sel = '0;
        endcase
    end

    // datapath
    always_comb
    begin
        max_disp_next  = max_disp_reg;
        sat_next       = sat_reg;
        val_next       = val_reg;
        run_max_next   = run_max_reg;
        black_next     = black_reg;
        mul_cnt_next   = mul_cnt_reg;
        hi_next        = hi_reg;
        r_next         = r_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        red_next       = red_reg;
        out_valid_next = out_valid_reg;
        out_b_next     = out_b_reg;
        out_g_next     = out_g_reg;
        out_r_next     = out_r_reg;
        scan_base      = pix_in.frame_start ? '0 : run_max_reg;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_MAX_DISP: max_disp_next = cfg.data[PIX_W-1:0];
                REG_SAT:      sat_next      = cfg.data;
                REG_VAL:      val_next      = cfg.data;
                default:      ;
            endcase
        end

        if (accept)
        begin
            if (!pix_in.op)
                run_max_next = (pix_in.pixel > scan_base) ? pix_in.pixel : scan_base;
            else
                black_next = is_black;
        end

        if (state_reg == ST_DIV && div_done)
        begin
            mul_cnt_next = '0;
            if (quotient >= 8'd240)
            begin
                hi_next = 3'd4;
                r_next  = FRAC_W'(quotient - 8'd240);
            end
            else if (quotient >= 8'd180)
            begin
                hi_next = 3'd3;
                r_next  = FRAC_W'(quotient - 8'd180);
            end
            else if (quotient >= 8'd120)
            begin
                hi_next = 3'd2;
                r_next  = FRAC_W'(quotient - 8'd120);
            end
            else if (quotient >= 8'd60)
            begin
                hi_next = 3'd1;
                r_next  = FRAC_W'(quotient - 8'd60);
            end
            else
            begin
                hi_next = 3'd0;
                r_next  = FRAC_W'(quotient);
            end
        end

        if (state_reg == ST_MUL)
        begin
            mul_cnt_next = mul_cnt_reg + 3'd1;
            case (mul_cnt_reg)
                3'd2:    blue_next  = chan;
                3'd3:    green_next = chan;
                3'd4:    red_next   = chan;
                default: ;
            endcase
        end

        if (out_valid_reg && pix_out.ready)
            out_valid_next = 1'b0;
        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_b_next     = black_reg ? '0 : blue_reg;
            out_g_next     = black_reg ? '0 : green_reg;
            out_r_next     = black_reg ? '0 : red_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_disp_reg  <= '0;
            sat_reg       <= LVL_ONE;
            val_reg       <= LVL_ONE;
            run_max_reg   <= '0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            max_disp_reg  <= max_disp_next;
            sat_reg       <= sat_next;
            val_reg       <= val_next;
            run_max_reg   <= run_max_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        black_reg <= black_next;
        hi_reg    <= hi_next;
        r_reg     <= r_next;
        blue_reg  <= blue_next;
        green_reg <= green_next;
        red_reg   <= red_next;
        out_b_reg <= out_b_next;
        out_g_reg <= out_g_next;
        out_r_reg <= out_r_next;
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.blue  = out_b_reg;
    assign pix_out.green = out_g_reg;
    assign pix_out.red   = out_r_reg;

endmodule
